>>> sv/gdda_pkg.sv
// shared types and constants of the grid dda ray caster
// no dependencies
`default_nettype none
package gdda_pkg;
  localparam int MapSide = 32;
  localparam int MapBits = 5;
  localparam int MapAddrBits = 2 * MapBits;
  localparam int MapDepth = MapSide * MapSide;
  localparam int FracBits = 16;
  localparam int TexBits = 6;
  localparam int StepMax = 2 * MapSide + 4;
  localparam logic [7:0] EmptyMark = 8'd42;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeRay = 1'b1;

  localparam logic [2:0] RegPosX = 3'd0;
  localparam logic [2:0] RegPosY = 3'd1;
  localparam logic [2:0] RegDirX = 3'd2;
  localparam logic [2:0] RegDirY = 3'd3;
  localparam logic [2:0] RegPlaneX = 3'd4;
  localparam logic [2:0] RegPlaneY = 3'd5;
  localparam logic [2:0] RegWidth = 3'd6;
  localparam logic [2:0] RegHeight = 3'd7;

  typedef struct packed {
    logic        mode;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [7:0]  cell_value;
    logic [10:0] column;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        out_column;
    logic signed [15:0] draw_start;
    logic [15:0]        draw_end;
    logic [5:0]         tex_column;
    logic               hit_side;
    logic [7:0]         wall_value;
    logic               left_grid;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_CAMDIV, ST_RAY, ST_SETUP, ST_CMP, ST_STEP, ST_LOOK,
    ST_LHDIV, ST_WDIV, ST_TEX, ST_OUT
  } state_t;

  // shared divider control
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [39:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [39:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> sv/gdda_div.sv
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on gdda_pkg
`default_nettype none
module gdda_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gdda_pkg::div_req_t req,
  output gdda_pkg::div_rsp_t     rsp
);
  import gdda_pkg::*;
  logic [63:0] quo;
  logic [40:0] rem;
  logic [39:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [40:0] trial;

  always_comb begin
    trial = {rem[39:0], quo[63]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (!trial[40]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[39:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[39:0];
endmodule
`default_nettype wire

>>> sv/gdda_map.sv
// map cell memory, one write and one registered read port
// depends on gdda_pkg
`default_nettype none
module gdda_map (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [gdda_pkg::MapAddrBits-1:0] waddr,
  input  wire logic [7:0]                     wdata,
  input  wire logic [gdda_pkg::MapAddrBits-1:0] raddr,
  output logic [7:0]                          rdata
);
  import gdda_pkg::*;
  logic [7:0] mem [MapDepth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/grid_dda_raycast_column_unit.sv
// grid dda ray caster, one screen column per transaction
// map write: taken while idle, the next transaction may follow at once
// ray: camera divide, ray and walk setup, a compare, step and lookup per cell,
// line-height and wall divides on one shared serial divider, texture, then
// the result waits for the receiver; the next transaction is taken in the cycle after the result is taken
// reset: configuration registers load defaults, a clearing pass zeroes all 1024 map cells
`default_nettype none
module grid_dda_raycast_column_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gdda_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gdda_pkg::out_item_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import gdda_pkg::*;

  // configuration registers
  logic [20:0] pos_x, pos_y;
  logic signed [18:0] dir_x, dir_y, plane_x, plane_y;
  logic [11:0] screen_width, screen_height;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= 21'd65536;
      pos_y <= 21'd65536;
      dir_x <= -19'sd65536;
      dir_y <= '0;
      plane_x <= '0;
      plane_y <= 19'sd43254;
      screen_width <= 12'd640;
      screen_height <= 12'd480;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegPosX:   pos_x <= pwdata[20:0];
        RegPosY:   pos_y <= pwdata[20:0];
        RegDirX:   dir_x <= pwdata[18:0];
        RegDirY:   dir_y <= pwdata[18:0];
        RegPlaneX: plane_x <= pwdata[18:0];
        RegPlaneY: plane_y <= pwdata[18:0];
        RegWidth:  screen_width <= pwdata[11:0];
        RegHeight: screen_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPosX:   prdata = {11'd0, pos_x};
      RegPosY:   prdata = {11'd0, pos_y};
      RegDirX:   prdata = {{13{dir_x[18]}}, dir_x};
      RegDirY:   prdata = {{13{dir_y[18]}}, dir_y};
      RegPlaneX: prdata = {{13{plane_x[18]}}, plane_x};
      RegPlaneY: prdata = {{13{plane_y[18]}}, plane_y};
      RegWidth:  prdata = {20'd0, screen_width};
      RegHeight: prdata = {20'd0, screen_height};
      default:   prdata = '0;
    endcase
  end

  // sequencer state
  state_t state, state_next;
  logic [MapAddrBits-1:0] clr_addr;
  logic [10:0] col;
  logic signed [18:0] cam;
  logic signed [19:0] rx, ry;
  logic [19:0] ax, ay;
  logic signed [7:0] mx, my;
  logic [23:0] nx, ny, last;
  logic side, left, flag_w;
  logic [6:0] steps;
  logic [7:0] wallv;
  logic [16:0] lh;
  logic [TexBits-1:0] tex;
  logic [1:0] ray_phase;
  logic signed [38:0] prod;

  div_req_t dreq;
  div_rsp_t drsp;
  gdda_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // map port
  logic map_we;
  logic [MapAddrBits-1:0] map_waddr, map_raddr;
  logic [7:0] map_wdata, map_rdata;
  gdda_map u_map (.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata));

  assign map_raddr = {mx[MapBits-1:0], my[MapBits-1:0]};

  // camera numerator and width
  logic [11:0] w_eff, c_eff;
  logic signed [13:0] cam_num;
  logic cam_neg;
  logic [12:0] cam_mag;
  always_comb begin
    w_eff   = (screen_width == 12'd0) ? 12'd1 : screen_width;
    c_eff   = ({1'b0, col} < w_eff) ? {1'b0, col} : w_eff - 12'd1;
    cam_num = $signed({1'b0, c_eff, 1'b0}) - $signed({2'b0, w_eff});
    cam_neg = cam_num[13];
    cam_mag = cam_neg ? 13'(-cam_num) : 13'(cam_num);
  end

  // cross-multiply compare, both products fit in 44 bits
  logic [43:0] px, py;
  logic out_map;
  assign px = 44'(nx) * 44'(ay);
  assign py = 44'(ny) * 44'(ax);
  always_comb begin
    out_map = (mx < 0) || (mx >= 8'(MapSide)) || (my < 0) || (my >= 8'(MapSide));
  end

  // wall and line-height support
  logic [19:0] r_hit;
  logic signed [19:0] s_oth;
  logic [20:0] p_oth;
  logic s_neg;
  logic [44:0] ds_mag;
  logic [63:0] wq_frac_d;
  logic [15:0] half_h, half_l;
  logic signed [16:0] draw_start_full;
  logic [16:0] draw_end_full;
  always_comb begin
    r_hit  = side ? ay : ax;
    s_oth  = side ? rx : ry;
    p_oth  = side ? pos_x : pos_y;
    s_neg  = s_oth[19];
    half_h = {5'd0, screen_height[11:1]};
    half_l = lh[16:1];
    draw_start_full = $signed({1'b0, half_h}) - $signed({1'b0, half_l});
    draw_end_full   = {1'b0, half_h} + {1'b0, half_l};
    wq_frac_d = 64'(last) * 64'(s_neg ? 20'(-s_oth) : 20'(s_oth));
    ds_mag    = wq_frac_d[44:0];
  end
  logic [FracBits-1:0] wq_low;
  logic [FracBits-1:0] fq;
  logic tex_mirror;
  assign tex_mirror = (side == 1'b0 && !rx[19] && rx != 0) || (side == 1'b1 && ry[19]);

  out_item_t res;

  always_comb begin
    state_next = state;
    dreq = '0;
    map_we = 1'b0;
    map_waddr = clr_addr;
    map_wdata = '0;
    in_stall = !(state == ST_IDLE);
    unique case (state)
      ST_IDLE: if (in_valid) begin
        if (in_data.mode == ModeWrite) begin
          map_we    = 1'b1;
          map_waddr = {in_data.cell_x, in_data.cell_y};
          map_wdata = in_data.cell_value;
        end else begin
          state_next = ST_CAMDIV;
        end
      end
      ST_CLEAR: begin
        map_we = 1'b1;
        if (clr_addr == MapAddrBits'(MapDepth - 1)) state_next = ST_IDLE;
      end
      ST_CAMDIV: begin
        if (!flag_w) begin
          dreq.start = 1'b1;
          dreq.num = 64'(cam_mag) << FracBits;
          dreq.den = 40'(w_eff);
        end else if (drsp.done) state_next = ST_RAY;
      end
      ST_RAY: if (ray_phase == 2'd3) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_CMP;
      ST_CMP: state_next = (steps >= 7'(StepMax)) ? ST_LHDIV : ST_STEP;
      ST_STEP: state_next = ST_LOOK;
      ST_LOOK: begin
        if (out_map || (map_rdata != 8'd0 && map_rdata != EmptyMark)) state_next = ST_LHDIV;
        else state_next = ST_CMP;
      end
      ST_LHDIV: begin
        if (r_hit == 20'd0) state_next = ST_OUT;
        else if (!flag_w) begin
          dreq.start = (last != 24'd0);
          dreq.num = 64'(screen_height) * 64'(r_hit);
          dreq.den = 40'(last);
          if (last == 24'd0) state_next = ST_WDIV;
        end else if (drsp.done) state_next = ST_WDIV;
      end
      ST_WDIV: begin
        if (!flag_w) begin
          dreq.start = 1'b1;
          dreq.num = 64'(ds_mag);
          dreq.den = 40'(r_hit);
        end else if (drsp.done) state_next = ST_TEX;
      end
      ST_TEX: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // floor division of a signed product: adjust magnitude quotient
  logic [63:0] fdq;
  assign fdq = (s_neg && drsp.rem != 0) ? drsp.quo + 64'd1 : drsp.quo;
  assign wq_low = s_neg ? FracBits'(p_oth[FracBits-1:0] - fdq[FracBits-1:0])
                        : FracBits'(p_oth[FracBits-1:0] + fdq[FracBits-1:0]);
  assign fq = wq_low;

  // flag_w marks a divide started in the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      flag_w <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state_next != state) flag_w <= 1'b0;
      else if (dreq.start) flag_w <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        col <= in_data.column;
        ray_phase <= '0;
      end
      ST_CAMDIV: if (drsp.done && flag_w)
        cam <= cam_neg ? -19'(drsp.quo[18:0]) : 19'(drsp.quo[18:0]);
      ST_RAY: begin
        ray_phase <= ray_phase + 2'd1;
        unique case (ray_phase)
          2'd0: prod <= 39'(plane_x) * 39'(cam);
          2'd1: begin
            rx <= 20'(dir_x) + 20'(prod >>> FracBits);
            prod <= 39'(plane_y) * 39'(cam);
          end
          2'd2: ry <= 20'(dir_y) + 20'(prod >>> FracBits);
          default: begin
            ax <= rx[19] ? 20'(-rx) : rx;
            ay <= ry[19] ? 20'(-ry) : ry;
          end
        endcase
      end
      ST_SETUP: begin
        mx <= 8'(pos_x[20:FracBits]);
        my <= 8'(pos_y[20:FracBits]);
        nx <= rx[19] ? 24'(pos_x[FracBits-1:0])
                     : 24'(1 << FracBits) - 24'(pos_x[FracBits-1:0]);
        ny <= ry[19] ? 24'(pos_y[FracBits-1:0])
                     : 24'(1 << FracBits) - 24'(pos_y[FracBits-1:0]);
        steps <= '0;
        left <= 1'b0;
        side <= 1'b0;
        last <= '0;
        wallv <= '0;
      end
      ST_CMP: begin
        if (steps >= 7'(StepMax)) left <= 1'b1;
        else if (px < py) begin
          last <= nx; nx <= nx + 24'(1 << FracBits);
          mx <= rx[19] ? mx - 8'sd1 : mx + 8'sd1; side <= 1'b0;
        end else begin
          last <= ny; ny <= ny + 24'(1 << FracBits);
          my <= ry[19] ? my - 8'sd1 : my + 8'sd1; side <= 1'b1;
        end
        steps <= steps + 7'd1;
        lh <= 17'd65535;
        tex <= '0;
      end
      ST_LOOK: begin
        if (out_map) left <= 1'b1;
        else wallv <= map_rdata;
      end
      ST_LHDIV: begin
        if (r_hit == 20'd0) lh <= '0;
        else if (drsp.done && flag_w)
          lh <= (drsp.quo > 64'd65535) ? 17'd65535 : 17'(drsp.quo);
      end
      ST_TEX: begin
        tex <= tex_mirror ? ~fq[FracBits-1 -: TexBits] : fq[FracBits-1 -: TexBits];
      end
      default: ;
    endcase
  end

  always_comb begin
    res.out_column = col;
    res.draw_start = draw_start_full[15:0];
    res.draw_end   = draw_end_full[15:0];
    res.tex_column = tex;
    res.hit_side   = side;
    res.wall_value = left ? 8'd0 : wallv;
    res.left_grid  = left;
  end

  assign out_valid = (state == ST_OUT);
  assign out_data  = res;
endmodule
`default_nettype wire

>>> test/grid_dda_raycast_column_unit_test.sv
// testbench for the grid dda ray caster: directed table, then random phases
// depends on gdda_pkg and grid_dda_raycast_column_unit
module grid_dda_raycast_column_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gdda_pkg::*;

  localparam int DrainCycles = 600;  // a ray in flight, divides included
  localparam int HoldCycles = 3000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // camera state and map mirror kept by the predictor
  longint cam_pos_x, cam_pos_y, cam_dir_x, cam_dir_y;
  longint cam_plane_x, cam_plane_y, scr_w, scr_h;
  logic [7:0] map_mirror [MapDepth];

  out_item_t pending_rays[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;

  always #5 clk = ~clk;

  grid_dda_raycast_column_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint sext19(longint v);
    logic signed [18:0] s;
    s = v[18:0];
    return longint'(s);
  endfunction

  // expected outcome of one ray, walking the mirrored map
  function automatic out_item_t cast_ray(in_item_t it);
    out_item_t o;
    longint one, w, c, cam, rx, ry, ax, ay, mx, my, nx, ny, last;
    longint lh, r, p, s, wq, tex;
    logic [7:0] v;
    bit side, left, hit;
    int steps;
    one = 64'd1 << FracBits;
    last = 0; tex = 0; side = 0; left = 0; hit = 0; v = 0;
    w = (scr_w != 0) ? scr_w : 1;
    c = (longint'(it.column) < w) ? longint'(it.column) : w - 1;
    cam = ((2 * c - w) * one) / w;
    rx = cam_dir_x + ((cam_plane_x * cam) >>> FracBits);
    ry = cam_dir_y + ((cam_plane_y * cam) >>> FracBits);
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    mx = cam_pos_x >> FracBits;
    my = cam_pos_y >> FracBits;
    nx = cam_pos_x - mx * one;
    ny = cam_pos_y - my * one;
    if (rx >= 0) nx = one - nx;
    if (ry >= 0) ny = one - ny;
    steps = 0;
    while (!hit && !left) begin
      if (steps >= StepMax) begin
        left = 1;
      end else begin
        if (nx * ay < ny * ax) begin
          last = nx; nx += one; mx += (rx < 0) ? -1 : 1; side = 0;
        end else begin
          last = ny; ny += one; my += (ry < 0) ? -1 : 1; side = 1;
        end
        if (mx < 0 || mx >= MapSide || my < 0 || my >= MapSide) begin
          left = 1;
        end else begin
          v = map_mirror[mx * MapSide + my];
          if (v != 0 && v != EmptyMark) hit = 1;
        end
      end
      steps++;
    end
    r = side ? ay : ax;
    if (r == 0) begin
      lh = 0;
    end else begin
      lh = (last == 0) ? 65535 : (scr_h * r) / last;
      if (lh > 65535) lh = 65535;
      p = side ? cam_pos_x : cam_pos_y;
      s = side ? rx : ry;
      wq = p + floor_quot(last * s, r);
      tex = ((wq & (one - 1)) * 64) >> FracBits;
      if ((!side && rx > 0) || (side && ry < 0)) tex = 63 - tex;
    end
    o.out_column = it.column;
    o.draw_start = 16'(scr_h / 2 - lh / 2);
    o.draw_end = 16'(scr_h / 2 + lh / 2);
    o.tex_column = 6'(tex);
    o.hit_side = side;
    o.wall_value = left ? 8'd0 : v;
    o.left_grid = left;
    return o;
  endfunction

  function automatic in_item_t make_item(logic m, int x, int y, int val, int col);
    in_item_t it;
    it.mode = m;
    it.cell_x = 5'(x);
    it.cell_y = 5'(y);
    it.cell_value = 8'(val);
    it.column = 11'(col);
    return it;
  endfunction

  // offer one transaction; on acceptance update the mirror or queue a ray
  task automatic offer(in_item_t it, bit typed, out_item_t want);
    int gap;
    gap = 0;
    while (gap < 400 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (it.mode == ModeWrite) begin
      map_mirror[it.cell_x * MapSide + it.cell_y] = it.cell_value;
    end else begin
      pending_rays.push_back(typed ? want : cast_ray(it));
    end
  endtask

  // stop offering, wait for every ray result, then let the clock run idle
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_rays.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // register write with setup and access phases, mirrored into the predictor
  task automatic reg_write(logic [2:0] idx, longint val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegPosX: cam_pos_x = val & 64'h1FFFFF;
      RegPosY: cam_pos_y = val & 64'h1FFFFF;
      RegDirX: cam_dir_x = sext19(val);
      RegDirY: cam_dir_y = sext19(val);
      RegPlaneX: cam_plane_x = sext19(val);
      RegPlaneY: cam_plane_y = sext19(val);
      RegWidth: scr_w = val & 64'hFFF;
      default: scr_h = val & 64'hFFF;
    endcase
  endtask

  task automatic set_camera(longint px, longint py, longint dx, longint dy,
                            longint lx, longint ly, longint w, longint h);
    reg_write(RegPosX, px);
    reg_write(RegPosY, py);
    reg_write(RegDirX, dx);
    reg_write(RegDirY, dy);
    reg_write(RegPlaneX, lx);
    reg_write(RegPlaneY, ly);
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
  endtask

  // receiver: random stall per cycle, or a long counted hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker against the oldest queued ray
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_rays.size() == 0) begin
        $error("unexpected ray result for column %0d", out_data.out_column);
        fail_count++;
      end else begin
        out_item_t e;
        e = pending_rays.pop_front();
        if (out_data.out_column !== e.out_column) begin
          $error("out_column exp %0d got %0d", e.out_column, out_data.out_column);
          fail_count++;
        end
        if (out_data.draw_start !== e.draw_start) begin
          $error("draw_start exp %0d got %0d", e.draw_start, out_data.draw_start);
          fail_count++;
        end
        if (out_data.draw_end !== e.draw_end) begin
          $error("draw_end exp %0d got %0d", e.draw_end, out_data.draw_end);
          fail_count++;
        end
        if (out_data.tex_column !== e.tex_column) begin
          $error("tex_column exp %0d got %0d", e.tex_column, out_data.tex_column);
          fail_count++;
        end
        if (out_data.hit_side !== e.hit_side) begin
          $error("hit_side exp %0d got %0d", e.hit_side, out_data.hit_side);
          fail_count++;
        end
        if (out_data.wall_value !== e.wall_value) begin
          $error("wall_value exp %0d got %0d", e.wall_value, out_data.wall_value);
          fail_count++;
        end
        if (out_data.left_grid !== e.left_grid) begin
          $error("left_grid exp %0d got %0d", e.left_grid, out_data.left_grid);
          fail_count++;
        end
      end
    end
  end

  // watchdog, far above the slowest legal run
  initial begin
    #100ms;
    $display("FAIL grid_dda_raycast_column_unit");
    $finish;
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    out_item_t none;
    in_item_t it;
    idle_mode_t mode_sel;
    int wall_pct;
    none = '0;
    cam_pos_x = 65536; cam_pos_y = 65536;
    cam_dir_x = -65536; cam_dir_y = 0;
    cam_plane_x = 0; cam_plane_y = 43254;
    scr_w = 640; scr_h = 480;
    foreach (map_mirror[i]) map_mirror[i] = 8'd0;

    // directed table; typed rows follow straight from the reset camera
    // center column on an empty map runs off the west edge
    row.item = make_item(ModeRay, 0, 0, 0, 320); row.typed = 1;
    row.want = '{out_column: 11'd320, draw_start: 16'sd0, draw_end: 16'd480,
                 tex_column: 6'd0, hit_side: 1'b0, wall_value: 8'd0, left_grid: 1'b1};
    rows.push_back(row);
    // wall right next to the camera boundary: zero distance, height saturates
    row.item = make_item(ModeWrite, 0, 1, 7, 0); row.typed = 0; row.want = none;
    rows.push_back(row);
    row.item = make_item(ModeRay, 0, 0, 0, 320); row.typed = 1;
    row.want = '{out_column: 11'd320, draw_start: -16'sd32527, draw_end: 16'd33007,
                 tex_column: 6'd0, hit_side: 1'b0, wall_value: 8'd7, left_grid: 1'b0};
    rows.push_back(row);
    // the empty mark is not a wall
    row.item = make_item(ModeWrite, 0, 1, 42, 0); row.typed = 0;
    rows.push_back(row);
    row.item = make_item(ModeRay, 0, 0, 0, 320); row.typed = 1;
    row.want = '{out_column: 11'd320, draw_start: 16'sd0, draw_end: 16'd480,
                 tex_column: 6'd0, hit_side: 1'b0, wall_value: 8'd0, left_grid: 1'b1};
    rows.push_back(row);
    row.typed = 0;
    row.item = make_item(ModeWrite, 31, 31, 255, 2047); rows.push_back(row);
    row.item = make_item(ModeWrite, 0, 0, 0, 0); rows.push_back(row);
    row.item = make_item(ModeWrite, 1, 0, 1, 0); rows.push_back(row);
    // wall on the start cell itself is never tested
    row.item = make_item(ModeWrite, 1, 1, 200, 0); rows.push_back(row);
    row.item = make_item(ModeWrite, 3, 1, 128, 0); rows.push_back(row);
    row.item = make_item(ModeRay, 31, 31, 255, 0); rows.push_back(row);
    row.item = make_item(ModeRay, 0, 0, 0, 639); rows.push_back(row);
    // column past the screen edge
    row.item = make_item(ModeRay, 0, 0, 0, 2047); rows.push_back(row);
    row.item = make_item(ModeRay, 0, 0, 0, 100); rows.push_back(row);
    row.item = make_item(ModeRay, 0, 0, 0, 500); rows.push_back(row);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // random phases, each with its own camera and idling pattern
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_camera(5 * 65536 + 32768, 7 * 65536 + 100, 0, 0, 0, 0, 640, 480);
        1: set_camera(2097151, 2097151, 131072, 131072, 131072, 131072, 2048, 2048);
        2: set_camera(0, 0, -131072, -131072, -131072, -131072, 1, 1);
        3: set_camera(16 * 65536, 16 * 65536, 65536, 0, 0, 43254, 0, 2048);
        default: set_camera($urandom_range(2097151), $urandom_range(2097151),
                             longint'($urandom_range(262144)) - 131072,
                             longint'($urandom_range(262144)) - 131072,
                             longint'($urandom_range(262144)) - 131072,
                             longint'($urandom_range(262144)) - 131072,
                             $urandom_range(2048, 1), $urandom_range(2048, 1));
      endcase
      mode_sel = idle_mode_t'(ph % 4);
      send_idle_pct = (mode_sel == IDLE_SEND) ? 88 : (mode_sel == IDLE_BOTH) ? 15 : 0;
      recv_stall_pct = (mode_sel == IDLE_RECV) ? 88 : (mode_sel == IDLE_BOTH) ? 15 : 0;
      wall_pct = $urandom_range(40, 5);
      for (int n = 0; n < 145; n++) begin
        // long receiver hold-off while rays keep coming
        if (ph == 4 && n == 20) hold_request = HoldCycles;
        // sender pause until the pipe is empty
        if (ph == 6 && n == 70 && pending_rays.size() != 0) begin
          in_valid <= 1'b0;
          wait (pending_rays.size() == 0);
        end
        if ($urandom_range(99) < 35) begin
          it = make_item(ModeWrite, $urandom_range(31), $urandom_range(31), 0,
                         $urandom_range(2047));
          if ($urandom_range(99) < wall_pct) it.cell_value = 8'($urandom_range(255, 1));
          else if ($urandom_range(1)) it.cell_value = EmptyMark;
        end else begin
          it = make_item(ModeRay, $urandom_range(31), $urandom_range(31),
                         $urandom_range(255), $urandom_range(2047));
          if ($urandom_range(3) != 0 && scr_w > 0)
            it.column = 11'($urandom_range(int'(scr_w) - 1));
        end
        offer(it, 0, none);
      end
      drain();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending_rays.size() == 0) begin
      $display("PASS grid_dda_raycast_column_unit");
    end else begin
      $display("FAIL grid_dda_raycast_column_unit");
    end
    $finish;
  end
endmodule
